/* hdl/pps_pkg.sv */
package pps_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;

	localparam int RAD_W = 63;
	localparam int ROOT_W = 32;

	localparam logic [31:0] K_R9_LO = 32'd1857120184;
	localparam logic [31:0] K_T24 = 32'd1640556661;
	localparam logic [31:0] K_X5 = 32'd3417826378;
	localparam logic [31:0] K_T11 = 32'd751921803;
	localparam logic [31:0] K_Y6 = 32'd4101391653;
	localparam logic [31:0] K_T08 = 32'd546852220;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam logic signed [15:0] WAVE_GAIN = 16'sd22938;
	localparam logic signed [15:0] RINGS_GAIN = 16'sd11469;
	localparam logic signed [17:0] BASE_OFFSET = 18'sd16384;
	localparam logic [19:0] DIV7_RECIP = 20'd599187;
	localparam logic [27:0] TQ_SAT_LIMIT = 28'd458752;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [17:0] THREE_Q16 = 18'd196608;
	localparam logic [20:0] DRIVE_BASE = 21'd29491;
	localparam logic [20:0] DRIVE_GAIN = 21'd24;
	localparam logic [15:0] RED_GAIN = 16'd55706;
	localparam logic [15:0] RED_OFFSET = 16'd2621;
	localparam logic [15:0] GREEN_GAIN = 16'd39322;
	localparam logic [15:0] GREEN_OFFSET = 16'd3277;
	localparam logic [15:0] BLUE_GAIN = 16'd26214;
	localparam logic [15:0] BLUE_OFFSET = 16'd8520;

	typedef enum logic [1:0] {
		REG_TIME_SECONDS = 2'd0,
		REG_AUDIO_LEVEL = 2'd1,
		REG_ASPECT_RATIO = 2'd2
	} reg_index_t;

	function automatic logic signed [15:0] sine_entry(input logic [63:0] turn);
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] val;
		q = {34'd0, turn[29:0]};
		if (turn[30]) begin
			q = 64'h4000_0000 - q;
		end
		x = (q * PI_Q30) >> 31;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		if (sum < 0) begin
			sum = 64'sd0;
		end
		val = ($unsigned(sum) + 64'd16384) >> 15;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return turn[31] ? -$signed(16'(val)) : $signed(16'(val));
	endfunction

endpackage

/* hdl/plasma_pattern_pixel_shader.sv */
// Channel   Signals                               Direction  Transaction
// input     start, busy, coord_u, coord_v         in         start high while busy low
// result    done, red, green, blue                out        done high for one cycle
// config    cfg_we, cfg_index, cfg_data           in         cfg_we high at a clock edge
//
// One pixel is accepted every clock cycle; busy is never raised.
// Each colour passes through the 32 stages of the square root, which resolves
// one root bit per stage, and through the multiplier stages around it.
// Reset clears the valid bits and loads the register defaults.
// Results cannot be held off, so nothing in the pipeline ever stalls.
module plasma_pattern_pixel_shader #(
	parameter int SINE_TABLE_DEPTH = pps_pkg::SINE_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] coord_u,
	input  logic signed [15:0] coord_v,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int LATENCY = 51;

	logic [31:0] time_q;
	logic [15:0] level_q;
	logic [15:0] aspect_q;
	logic [31:0] tph1_q;
	logic [31:0] tph2_q;
	logic [31:0] tph3_q;
	logic [63:0] tp1;
	logic [63:0] tp2;
	logic [63:0] tp3;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_s37, vld_s38, vld_s39, vld_s40;
	logic signed [15:0] u_s1, v_s1;
	logic signed [31:0] px_s2;
	logic signed [15:0] v_s2;
	logic [31:0] ph3_s2;
	logic signed [64:0] p2;
	logic signed [47:0] p3;
	logic [61:0] pxsq_s3;
	logic [31:0] vsq_s3;
	logic [31:0] ph2_s3, ph3_s3;
	logic [62:0] n_s4;
	logic [31:0] ph2_s4, ph3_s4;

	logic vld_s36;
	logic [31:0] r_s36;
	logic [63:0] side_s36;
	logic [63:0] rk_s37;
	logic [31:0] r_s37, r_s38, r_s39, r_s40;
	logic [63:0] side_s37;
	logic [31:0] ph1_s38, ph2_s38, ph3_s38;
	logic signed [15:0] sin1, sin2, sin3;

	assign busy = 1'b0;
	assign p2 = px_s2 * $signed({1'b0, pps_pkg::K_X5});
	assign p3 = v_s1 * $signed({1'b0, pps_pkg::K_Y6});
	assign tp1 = 64'(time_q) * 64'(pps_pkg::K_T24);
	assign tp2 = 64'(time_q) * 64'(pps_pkg::K_T11);
	assign tp3 = 64'(time_q) * 64'(pps_pkg::K_T08);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			level_q <= '0;
			aspect_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				pps_pkg::REG_TIME_SECONDS: time_q <= cfg_data;
				pps_pkg::REG_AUDIO_LEVEL: level_q <= cfg_data[15:0];
				pps_pkg::REG_ASPECT_RATIO: aspect_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s37 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s37 <= vld_s36;
			vld_s38 <= vld_s37;
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
		end
	end

	always_ff @(posedge clk) begin
		tph1_q <= tp1[47:16];
		tph2_q <= tp2[47:16];
		tph3_q <= tp3[47:16];

		u_s1 <= coord_u;
		v_s1 <= coord_v;

		px_s2 <= 32'(u_s1) * 32'($signed({1'b0, aspect_q}));
		v_s2 <= v_s1;
		ph3_s2 <= p3[46:15];

		pxsq_s3 <= 62'(64'(px_s2) * 64'(px_s2));
		vsq_s3 <= 32'(v_s2) * 32'(v_s2);
		ph2_s3 <= p2[54:23];
		ph3_s3 <= ph3_s2;

		n_s4 <= 63'(pxsq_s3) + {15'd0, vsq_s3, 16'd0};
		ph2_s4 <= ph2_s3;
		ph3_s4 <= ph3_s3;

		rk_s37 <= 64'(r_s36) * 64'(pps_pkg::K_R9_LO);
		r_s37 <= r_s36;
		side_s37 <= side_s36;

		ph1_s38 <= {r_s37[22:0], 9'd0} + rk_s37[54:23] - tph1_q;
		ph2_s38 <= side_s37[63:32] + tph2_q;
		ph3_s38 <= side_s37[31:0] - tph3_q;
		r_s38 <= r_s37;

		r_s39 <= r_s38;
		r_s40 <= r_s39;
	end

	pps_isqrt #(
		.SIDE_W(64)
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s4),
		.in_rad(n_s4),
		.in_side({ph2_s4, ph3_s4}),
		.out_vld(vld_s36),
		.out_root(r_s36),
		.out_side(side_s36)
	);

	pps_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_rad (
		.clk(clk), .phase(ph1_s38), .sample(sin1)
	);

	pps_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_x (
		.clk(clk), .phase(ph2_s38), .sample(sin2)
	);

	pps_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_y (
		.clk(clk), .phase(ph3_s38), .sample(sin3)
	);

	pps_shade u_shade (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s40),
		.sin_rad(sin1),
		.sin_x(sin2),
		.sin_y(sin3),
		.radius(r_s40),
		.level(level_q),
		.out_vld(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s38 |-> $past(vld_s4, 34))
		else $error("valid bit lost its item in the square root pipeline");

endmodule

/* hdl/pps_isqrt.sv */
module pps_isqrt #(
	parameter int SIDE_W = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [pps_pkg::RAD_W-1:0]     in_rad,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [pps_pkg::ROOT_W-1:0]    out_root,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int RW = pps_pkg::RAD_W;
	localparam int QW = pps_pkg::ROOT_W;

	logic [RW-1:0] rem_s [1:QW];
	logic [QW-1:0] root_s [1:QW];
	logic vld_s [1:QW];
	logic [SIDE_W-1:0] side_s [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int B = QW - 1 - i;
		logic [RW-1:0] cur_rem;
		logic [QW-1:0] cur_root;
		logic cur_vld;
		logic [SIDE_W-1:0] cur_side;
		logic [RW:0] trial;
		logic take;

		if (i == 0) begin : g_first
			assign cur_rem = in_rad;
			assign cur_root = '0;
			assign cur_vld = in_vld;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_rem = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_vld = vld_s[i];
			assign cur_side = side_s[i];
		end

		assign trial = ((RW+1)'(cur_root) << (B + 1)) | ((RW+1)'(1) << (2 * B));
		assign take = {1'b0, cur_rem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? RW'({1'b0, cur_rem} - trial) : cur_rem;
			root_s[i+1] <= take ? (cur_root | (QW'(1) << B)) : cur_root;
			side_s[i+1] <= cur_side;
		end
	end

	assign out_vld = vld_s[QW];
	assign out_root = root_s[QW];
	assign out_side = side_s[QW];

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> rem_s[QW] <= {root_s[QW], 1'b0})
		else $error("square root remainder exceeds twice the root");

endmodule

/* hdl/pps_sine.sv */
module pps_sine #(
	parameter int DEPTH = pps_pkg::SINE_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [15:0] sample
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SCL_W = IDX_W + 33;

	logic signed [15:0] rom [DEPTH];
	logic [SCL_W-1:0] scaled;
	logic [IDX_W:0] idx_raw;
	logic [IDX_W-1:0] idx_s1;

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic [63:0] TURN = (64'(k) << 32) / DEPTH;
		assign rom[k] = pps_pkg::sine_entry(TURN);
	end

	assign scaled = SCL_W'(phase) * SCL_W'(DEPTH) + (SCL_W'(1) << 31);
	assign idx_raw = scaled[SCL_W-1:32];

	always_ff @(posedge clk) begin
		if (idx_raw >= (IDX_W+1)'(DEPTH)) begin
			idx_s1 <= IDX_W'(idx_raw - (IDX_W+1)'(DEPTH));
		end else begin
			idx_s1 <= idx_raw[IDX_W-1:0];
		end
		sample <= rom[idx_s1];
	end

endmodule

/* hdl/pps_shade.sv */
module pps_shade (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [15:0] sin_rad,
	input  logic signed [15:0] sin_x,
	input  logic signed [15:0] sin_y,
	input  logic [31:0]        radius,
	input  logic [15:0]        level,
	output logic               out_vld,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic [11:1] vld_s;
	logic [20:0] drive_q;

	logic signed [16:0] sum23;
	logic signed [31:0] m1_s1;
	logic signed [15:0] sin1_s1;
	logic [27:0] b_s1;
	logic signed [17:0] rings_s2;
	logic [38:0] q7_s2;
	logic sat_s2;
	logic signed [32:0] m2_s3;
	logic [16:0] tq_s3;
	logic signed [17:0] base_s4;
	logic [32:0] tqsq_s4;
	logic [16:0] tq_s4;
	logic [50:0] cubic;
	logic [16:0] falloff_s5;
	logic signed [17:0] base_s5;
	logic [32:0] bf_s6;
	logic zero_s6;
	logic [53:0] bfd_s7;
	logic zero_s7;
	logic [22:0] hi;
	logic [16:0] inten_s8;
	logic [33:0] isq;
	logic [32:0] gp;
	logic [32:0] bp;
	logic [16:0] i2_s9;
	logic [15:0] g_s9;
	logic [15:0] b_s9;
	logic [32:0] rp;
	logic [15:0] rq_s10;
	logic [15:0] gq_s10;
	logic [15:0] bq_s10;
	logic [24:0] rt;
	logic [24:0] gt;
	logic [24:0] bt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[10:1], in_vld};
		end
	end

	assign sum23 = 17'(sin_x) + 17'(sin_y);
	assign cubic = 51'(tqsq_s4) * 51'(pps_pkg::THREE_Q16 - {tq_s4, 1'b0});
	assign hi = bfd_s7[53:31];
	assign isq = 34'(inten_s8) * 34'(inten_s8);
	assign gp = 33'(inten_s8) * 33'(pps_pkg::GREEN_GAIN);
	assign bp = 33'(inten_s8) * 33'(pps_pkg::BLUE_GAIN);
	assign rp = 33'(i2_s9) * 33'(pps_pkg::RED_GAIN);
	assign rt = {1'b0, rq_s10, 8'd0} - 25'(rq_s10) + 25'd32768;
	assign gt = {1'b0, gq_s10, 8'd0} - 25'(gq_s10) + 25'd32768;
	assign bt = {1'b0, bq_s10, 8'd0} - 25'(bq_s10) + 25'd32768;

	always_ff @(posedge clk) begin
		drive_q <= pps_pkg::DRIVE_BASE + 21'(level) * pps_pkg::DRIVE_GAIN;

		m1_s1 <= sum23 * pps_pkg::WAVE_GAIN;
		sin1_s1 <= sin_rad;
		b_s1 <= 28'(({3'b000, radius} + {1'b0, radius, 2'b00}) >> 7);

		rings_s2 <= 18'(sin1_s1) + 18'(m1_s1 >>> 15);
		q7_s2 <= 39'(b_s1[18:0]) * 39'(pps_pkg::DIV7_RECIP);
		sat_s2 <= b_s1 >= pps_pkg::TQ_SAT_LIMIT;

		m2_s3 <= rings_s2 * pps_pkg::RINGS_GAIN;
		tq_s3 <= sat_s2 ? pps_pkg::ONE_Q16 : {1'b0, q7_s2[37:22]};

		base_s4 <= 18'(m2_s3 >>> 15) + pps_pkg::BASE_OFFSET;
		tqsq_s4 <= 33'(tq_s3) * 33'(tq_s3);
		tq_s4 <= tq_s3;

		falloff_s5 <= pps_pkg::ONE_Q16 - cubic[48:32];
		base_s5 <= base_s4;

		bf_s6 <= 33'(base_s5[15:0]) * 33'(falloff_s5);
		zero_s6 <= base_s5[17] || (base_s5 == 18'sd0);

		bfd_s7 <= 54'(bf_s6) * 54'(drive_q);
		zero_s7 <= zero_s6;

		if (zero_s7) begin
			inten_s8 <= '0;
		end else if (hi > 23'(pps_pkg::ONE_Q16)) begin
			inten_s8 <= pps_pkg::ONE_Q16;
		end else begin
			inten_s8 <= hi[16:0];
		end

		i2_s9 <= isq[32:16];
		g_s9 <= gp[31:16];
		b_s9 <= bp[31:16];

		rq_s10 <= rp[31:16] + pps_pkg::RED_OFFSET;
		gq_s10 <= g_s9 + pps_pkg::GREEN_OFFSET;
		bq_s10 <= b_s9 + pps_pkg::BLUE_OFFSET;

		red <= rt[23:16];
		green <= gt[23:16];
		blue <= bt[23:16];
	end

	assign out_vld = vld_s[11];

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> falloff_s5 <= pps_pkg::ONE_Q16)
		else $error("falloff above one");

endmodule
